// ===== sv/rtufld_pkg.sv =====
`timescale 1ns / 1ps
package rtufld_pkg;

  localparam int MAX_FRAME  = 256;
  localparam int MIN_CAP    = 4;
  localparam int CNT_W      = 9;
  localparam int MS_W       = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [MS_W-1:0]  GAP_RST   = 16'd50;
  localparam logic [MS_W-1:0]  FRAME_RST = 16'd100;
  localparam logic [CNT_W-1:0] CAP_RST   = 9'(MAX_FRAME);
  localparam logic [MS_W-1:0]  MS_MAX    = '1;

  // frame layout pieces, in bytes
  localparam logic [CNT_W-1:0] HDR_LEN   = 9'd3;
  localparam logic [CNT_W-1:0] CRC_LEN   = 9'd2;
  localparam logic [CNT_W-1:0] LEN_EXC   = 9'd5;  // addr, func, code, crc
  localparam logic [CNT_W-1:0] LEN_WRITE = 9'd6;  // addr, func, 2 data, crc
  localparam logic [CNT_W-1:0] LEN_OTHER = 9'd4;  // addr, func, crc

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_RECV    = 2'd1,
    ST_DONE    = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_GAP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUF_CAP    = 2'd2;

  localparam logic [7:0] FC_READ_COILS  = 8'h01;
  localparam logic [7:0] FC_READ_DISC   = 8'h02;
  localparam logic [7:0] FC_READ_HOLD   = 8'h03;
  localparam logic [7:0] FC_READ_INPUT  = 8'h04;
  localparam logic [7:0] FC_WRITE_COIL  = 8'h05;
  localparam logic [7:0] FC_WRITE_REG   = 8'h06;
  localparam logic [7:0] FC_WRITE_COILS = 8'h0F;
  localparam logic [7:0] FC_WRITE_REGS  = 8'h10;
  localparam logic [7:0] FC_RW_REGS     = 8'h17;
  localparam logic [7:0] FC_DEV_ID      = 8'h2B;

  typedef struct packed {
    logic start;
    logic byte_seen;
    logic tick;
  } timer_ctrl_t;

  function automatic logic [CNT_W-1:0] length_for(input logic [7:0] fc,
                                                  input logic [7:0] cnt);
    logic [CNT_W-1:0] len;
    len = LEN_OTHER;
    if (fc[7]) begin
      len = LEN_EXC;
    end else begin
      case (fc)
        FC_READ_COILS, FC_READ_DISC, FC_READ_HOLD, FC_READ_INPUT,
        FC_WRITE_COILS, FC_WRITE_REGS, FC_RW_REGS: begin
          len = HDR_LEN + {1'b0, cnt} + CRC_LEN;
        end
        FC_WRITE_COIL, FC_WRITE_REG: len = LEN_WRITE;
        FC_DEV_ID: len = LEN_EXC;
        default: len = LEN_OTHER;
      endcase
    end
    return len;
  endfunction

endpackage

// ===== sv/rtufld_if.sv =====
`timescale 1ns / 1ps
interface rtufld_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] data_byte;

  modport source (output valid, operation, data_byte, input ready);
  modport sink (input valid, operation, data_byte, output ready);
endinterface

interface rtufld_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [8:0] byte_total;
  logic       byte_valid;
  logic [7:0] byte_value;
  logic [7:0] byte_position;

  modport source (output valid, status, byte_total, byte_valid, byte_value,
                  byte_position, input ready);
  modport sink (input valid, status, byte_total, byte_valid, byte_value,
                byte_position, output ready);
endinterface

// ===== sv/rtufld_timer.sv =====
`timescale 1ns / 1ps
module rtufld_timer
  import rtufld_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  timer_ctrl_t     ctrl,
  input  logic [MS_W-1:0] gap_limit,
  input  logic [MS_W-1:0] frame_limit,
  output logic            timeout
);

  logic [MS_W-1:0] idle_ms_r, idle_ms_nxt;
  logic [MS_W-1:0] frame_ms_r, frame_ms_nxt;
  logic [MS_W-1:0] idle_inc, frame_inc;

  // saturating increments
  assign idle_inc  = (idle_ms_r == MS_MAX) ? MS_MAX : idle_ms_r + 1'b1;
  assign frame_inc = (frame_ms_r == MS_MAX) ? MS_MAX : frame_ms_r + 1'b1;

  // a limit would be passed if a tick came in now
  assign timeout = (idle_inc > gap_limit) || (frame_inc > frame_limit);

  always_comb begin
    idle_ms_nxt  = idle_ms_r;
    frame_ms_nxt = frame_ms_r;
    if (ctrl.start) begin
      idle_ms_nxt  = '0;
      frame_ms_nxt = '0;
    end else if (ctrl.byte_seen) begin
      idle_ms_nxt = '0;
    end else if (ctrl.tick) begin
      idle_ms_nxt  = idle_inc;
      frame_ms_nxt = frame_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_ms_r  <= '0;
      frame_ms_r <= '0;
    end else begin
      idle_ms_r  <= idle_ms_nxt;
      frame_ms_r <= frame_ms_nxt;
    end
  end

endmodule

// ===== sv/rtu_frame_length_detector.sv =====
`timescale 1ns / 1ps
// Result register: a result appears on out_if in the cycle after its request is accepted.
// Throughput: one request per cycle; in_if.ready drops only while a result
//   waits in the result register and out_if.ready is low.
// Reset (rst_n, synchronous, active low): not receiving, counters cleared,
//   result register empty, limits back to 50 ms / 100 ms / 256 bytes.
module rtu_frame_length_detector
  import rtufld_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  rtufld_in_if.sink             in_if,
  rtufld_out_if.source          out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [MS_W-1:0]  gap_limit_r;
  logic [MS_W-1:0]  frame_limit_r;
  logic [CNT_W-1:0] buf_cap_r;
  logic [CNT_W-1:0] eff_cap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r   <= GAP_RST;
      frame_limit_r <= FRAME_RST;
      buf_cap_r     <= CAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BYTE_GAP:   gap_limit_r   <= cfg_data;
        CFG_FRAME_TIME: frame_limit_r <= cfg_data;
        CFG_BUF_CAP:    buf_cap_r     <= cfg_data[CNT_W-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // capacity clamped into [MIN_CAP, MAX_FRAME]
  always_comb begin
    eff_cap = buf_cap_r;
    if (buf_cap_r < CNT_W'(MIN_CAP)) eff_cap = CNT_W'(MIN_CAP);
    else if (buf_cap_r > CNT_W'(MAX_FRAME)) eff_cap = CNT_W'(MAX_FRAME);
  end

  // ---------------------------------------------------------------
  // Handshake: result register decouples the two sides
  // ---------------------------------------------------------------
  logic out_v_r;
  logic accept;

  assign in_if.ready = !out_v_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;

  // ---------------------------------------------------------------
  // Receive state
  // ---------------------------------------------------------------
  logic             active_r, active_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] exp_len_r, exp_len_nxt;   // zero: not yet known
  logic [7:0]       func_r, func_nxt;

  op_t         op;
  timer_ctrl_t tmr_ctrl;
  logic        timeout;
  logic [1:0]  status;
  logic        bv;
  logic [7:0]  bval;
  logic [7:0]  bpos;
  logic [CNT_W-1:0] cnt_inc;

  assign op      = op_t'(in_if.operation);
  assign cnt_inc = cnt_r + 1'b1;

  always_comb begin
    active_nxt   = active_r;
    cnt_nxt      = cnt_r;
    exp_len_nxt  = exp_len_r;
    func_nxt     = func_r;
    tmr_ctrl     = '0;
    status       = active_r ? ST_RECV : ST_IDLE;
    bv           = 1'b0;
    bval         = '0;
    bpos         = '0;
    case (op)
      OP_START: begin
        // start (also restarts a running receive)
        active_nxt     = 1'b1;
        cnt_nxt        = '0;
        exp_len_nxt    = '0;
        func_nxt       = '0;
        tmr_ctrl.start = 1'b1;
        status         = ST_RECV;
      end
      OP_BYTE: begin
        if (active_r) begin
          bv                 = 1'b1;
          bval               = in_if.data_byte;
          bpos               = cnt_r[7:0];
          cnt_nxt            = cnt_inc;
          tmr_ctrl.byte_seen = 1'b1;
          if (cnt_inc == 9'd2) func_nxt = in_if.data_byte;
          // third byte settles the length (byte count for bulk codes)
          if (cnt_inc == 9'd3 && exp_len_r == '0)
            exp_len_nxt = length_for(func_r, in_if.data_byte);
          if ((exp_len_nxt != '0 && cnt_inc >= exp_len_nxt) || cnt_inc >= eff_cap) begin
            active_nxt = 1'b0;
            status     = ST_DONE;
          end else begin
            status = ST_RECV;
          end
        end
      end
      OP_TICK: begin
        if (active_r) begin
          tmr_ctrl.tick = 1'b1;
          if (timeout) begin
            active_nxt = 1'b0;
            status     = ST_TIMEOUT;
          end else begin
            status = ST_RECV;
          end
        end
      end
      default: ;  // unused opcode: no state change
    endcase
    if (!accept) tmr_ctrl = '0;
  end

  rtufld_timer u_timer (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (tmr_ctrl),
    .gap_limit   (gap_limit_r),
    .frame_limit (frame_limit_r),
    .timeout     (timeout)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      cnt_r     <= '0;
      exp_len_r <= '0;
      func_r    <= '0;
    end else if (accept) begin
      active_r  <= active_nxt;
      cnt_r     <= cnt_nxt;
      exp_len_r <= exp_len_nxt;
      func_r    <= func_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  logic [1:0]       res_status_r;
  logic [CNT_W-1:0] res_len_r;
  logic             res_bv_r;
  logic [7:0]       res_bval_r;
  logic [7:0]       res_bpos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (accept) begin
      out_v_r <= 1'b1;
    end else if (out_if.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_status_r <= status;
      res_len_r    <= cnt_nxt;
      res_bv_r     <= bv;
      res_bval_r   <= bval;
      res_bpos_r   <= bpos;
    end
  end

  assign out_if.valid         = out_v_r;
  assign out_if.status        = res_status_r;
  assign out_if.byte_total    = res_len_r;
  assign out_if.byte_valid    = res_bv_r;
  assign out_if.byte_value    = res_bval_r;
  assign out_if.byte_position = res_bpos_r;

`ifndef SYNTHESIS
  // a stored byte is only ever reported while receiving or on completion
  a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_bv_r |-> (res_status_r == ST_RECV || res_status_r == ST_DONE))
    else $error("byte reported with idle or timeout status");

  // a start request always leaves the block receiving
  a_start_active: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_if.operation == OP_START |=> active_r)
    else $error("start did not open a receive");

  // capacity bounds the byte count
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_FRAME))
    else $error("byte count beyond frame maximum");

  // an empty result register never blocks requests
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_if.ready)
    else $error("request blocked with empty result register");
`endif

endmodule
